>>> rtl/fnv1a_folded_string_hash_assert.svh
// assertion macros for the folded fnv-1a string hash
`ifndef FNV1A_FOLDED_STRING_HASH_ASSERT_SVH
`define FNV1A_FOLDED_STRING_HASH_ASSERT_SVH

`ifndef SYNTHESIS
`define FNV1A_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define FNV1A_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define FNV1A_ASSERT(label, prop, msg)
`define FNV1A_ASSERT_RST(label, prop, msg)
`endif

`endif

>>> rtl/fnv1a_pkg.sv
`timescale 1ns / 1ps
package fnv1a_pkg;

    localparam int HASH_W = 32;
    localparam int BYTE_W = 8;
    localparam int FOLD_W = 6;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
    localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

    localparam logic [FOLD_W-1:0] FOLD_RESET = 6'd32;

    localparam logic REG_FOLD_BITS = 1'b0;
    localparam logic REG_CASE_FOLD = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              hash_en;
        logic              last;
    } item_t;

endpackage

>>> rtl/fnv1a_folded_string_hash.sv
// m_valid is registered when the back end pops the last byte of a key
// throughput: one key byte per cycle while s_ready is high, set by the constant
// multiply in the back-end accumulator loop; keys follow each other with no gap
// reset: synchronous active-low aresetn empties the queue, drops any pending
// result, restores the offset basis and sets fold_bits to 32 and case_fold to 0
`timescale 1ns / 1ps
`include "fnv1a_folded_string_hash_assert.svh"
module fnv1a_folded_string_hash #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fnv1a_pkg::ADDR_W-1:0] paddr,
    input  logic [fnv1a_pkg::DATA_W-1:0] pwdata,
    output logic [fnv1a_pkg::DATA_W-1:0] prdata,
    output logic                         pready,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [fnv1a_pkg::BYTE_W-1:0] s_data_byte,
    input  logic                         s_last,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [fnv1a_pkg::HASH_W-1:0] m_hash_value
);
    import fnv1a_pkg::*;

    logic [FOLD_W-1:0] fold_bits_reg;
    logic              case_fold_reg;
    logic              cfg_write;
    logic              push_valid;
    logic              push_ready;
    item_t             push_item;
    logic              q_valid;
    logic              q_ready;
    item_t             q_item;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_bits_reg <= FOLD_RESET;
            case_fold_reg <= 1'b0;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_FOLD_BITS: fold_bits_reg <= pwdata[FOLD_W-1:0];
                REG_CASE_FOLD: case_fold_reg <= pwdata[0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_FOLD_BITS: prdata = {{(DATA_W - FOLD_W){1'b0}}, fold_bits_reg};
            REG_CASE_FOLD: prdata = {{(DATA_W - 1){1'b0}}, case_fold_reg};
            default:       prdata = '0;
        endcase
    end

    fnv1a_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .case_fold   (case_fold_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last      (s_last),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_item   (push_item)
    );

    fnv1a_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_item   (push_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    fnv1a_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fold_bits    (fold_bits_reg),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value)
    );

    `FNV1A_ASSERT(a_last_result, (q_valid && q_ready && q_item.last) |=> m_valid, "no result")
    `FNV1A_ASSERT(a_hold, (q_valid && q_item.last && m_valid && !m_ready) |-> !q_ready, "overwrite")
    `FNV1A_ASSERT_RST(a_reset_clears, !aresetn |=> !m_valid, "valid after reset")

endmodule

>>> rtl/fnv1a_front.sv
`timescale 1ns / 1ps
module fnv1a_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      case_fold,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [fnv1a_pkg::BYTE_W-1:0] s_data_byte,
    input  logic                      s_last,
    output logic                      push_valid,
    input  logic                      push_ready,
    output fnv1a_pkg::item_t          push_item
);
    import fnv1a_pkg::*;

    logic              stopped_reg;
    logic              stopped_next;
    logic [BYTE_W-1:0] folded_byte;
    logic              is_zero;
    logic              keep;
    logic              accept;

    always_comb begin
        folded_byte = s_data_byte;
        if (case_fold && s_data_byte >= 8'h61 && s_data_byte <= 8'h7E) begin
            folded_byte = s_data_byte - 8'h20;
        end
    end

    assign is_zero = (s_data_byte == '0);
    assign keep    = s_last || (!stopped_reg && !is_zero);
    assign s_ready = push_ready;
    assign accept  = s_valid && s_ready;

    assign push_valid          = s_valid && keep;
    assign push_item.data_byte = folded_byte;
    assign push_item.hash_en   = !stopped_reg && !is_zero;
    assign push_item.last      = s_last;

    // zero byte ends hashing until the last transfer of the key
    always_comb begin
        stopped_next = stopped_reg;
        if (accept) begin
            if (s_last) begin
                stopped_next = 1'b0;
            end else if (is_zero) begin
                stopped_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stopped_reg <= 1'b0;
        end else begin
            stopped_reg <= stopped_next;
        end
    end

endmodule

>>> rtl/fnv1a_fifo.sv
`timescale 1ns / 1ps
module fnv1a_fifo #(
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  fnv1a_pkg::item_t in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output fnv1a_pkg::item_t out_item
);
    import fnv1a_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t         entries [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          push;
    logic          pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = entries[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= in_item;
        end
    end

endmodule

>>> rtl/fnv1a_back.sv
`timescale 1ns / 1ps
module fnv1a_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [fnv1a_pkg::FOLD_W-1:0] fold_bits,
    input  logic                         q_valid,
    output logic                         q_ready,
    input  fnv1a_pkg::item_t             q_item,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [fnv1a_pkg::HASH_W-1:0] m_hash_value
);
    import fnv1a_pkg::*;

    function automatic logic [HASH_W-1:0] fold_hash(input logic [HASH_W-1:0] h,
                                                    input logic [FOLD_W-1:0] bits);
        logic [HASH_W-1:0] mask;
        mask = ~({HASH_W{1'b1}} << bits);
        if (bits < FOLD_W'(HASH_W)) begin
            return ((h >> bits) ^ h) & mask;
        end
        return h;
    endfunction

    logic [HASH_W-1:0] acc_reg;
    logic [HASH_W-1:0] acc_next;
    logic [HASH_W-1:0] mixed;
    logic [HASH_W-1:0] product;
    logic [HASH_W-1:0] hashed;
    logic [HASH_W-1:0] hash_reg;
    logic              m_valid_reg;
    logic              out_free;
    logic              pop;

    assign out_free = !m_valid_reg || m_ready;
    assign q_ready  = !q_item.last || out_free;
    assign pop      = q_valid && q_ready;

    assign mixed   = acc_reg ^ {{(HASH_W - BYTE_W){1'b0}}, q_item.data_byte};
    assign product = mixed * FNV_PRIME;
    assign hashed  = q_item.hash_en ? product : acc_reg;

    always_comb begin
        acc_next = acc_reg;
        if (pop) begin
            acc_next = q_item.last ? FNV_BASIS : hashed;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= FNV_BASIS;
            m_valid_reg <= 1'b0;
        end else begin
            acc_reg <= acc_next;
            if (pop && q_item.last) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && q_item.last) begin
            hash_reg <= fold_hash(hashed, fold_bits);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_hash_value = hash_reg;

endmodule

>>> tb/fnv1a_folded_string_hash_tb.sv
`timescale 1ns / 1ps
module fnv1a_folded_string_hash_tb;
    import fnv1a_pkg::*;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [ADDR_W-1:0]   paddr       = '0;
    logic [DATA_W-1:0]   pwdata      = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    logic [BYTE_W-1:0]   s_data_byte = '0;
    logic                s_last      = 1'b0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    logic [HASH_W-1:0]   m_hash_value;

    // predictor state
    logic [FOLD_W-1:0]   fold_width  = FOLD_RESET;
    logic                case_upper  = 1'b0;
    logic [HASH_W-1:0]   acc         = FNV_BASIS;
    logic                acc_stopped = 1'b0;

    logic [HASH_W-1:0]   expected_hashes[$];
    logic [HASH_W-1:0]   hash_want;
    int                  errors      = 0;
    int                  bytes_sent  = 0;
    int                  keys_sent   = 0;
    int                  hashes_seen = 0;
    int                  cfg_writes  = 0;
    bit                  gaps_on     = 1'b1;

    fnv1a_folded_string_hash dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_last       (s_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #4000000;
        $display("timeout with %0d hashes outstanding", expected_hashes.size());
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        errors++;
        $display("%0t mismatch: %s", $realtime, what);
    endtask

    function automatic logic [HASH_W-1:0] fold_hash(input logic [HASH_W-1:0] h,
                                                    input logic [FOLD_W-1:0] w);
        if (w < HASH_W)
            return ((h >> w) ^ h) & ((32'd1 << w) - 32'd1);
        return h;
    endfunction

    task automatic absorb_byte(input logic [BYTE_W-1:0] b, input logic l);
        logic [BYTE_W-1:0] c;
        c = b;
        if (!acc_stopped) begin
            if (b == 8'h00) begin
                acc_stopped = 1'b1;
            end else begin
                if (case_upper && c >= 8'h61 && c <= 8'h7E)
                    c = c - 8'h20;
                acc = (acc ^ {24'h0, c}) * FNV_PRIME;
            end
        end
        if (l) begin
            expected_hashes.push_back(fold_hash(acc, fold_width));
            acc = FNV_BASIS;
            acc_stopped = 1'b0;
        end
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic l);
        while (gaps_on && $urandom_range(0, 99) < 38) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last      <= l;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        absorb_byte(b, l);
        bytes_sent++;
        if (l)
            keys_sent++;
    endtask

    task automatic pause_until_drained();
        s_valid <= 1'b0;
        while (expected_hashes.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (idx == REG_FOLD_BITS)
            fold_width = value[FOLD_W-1:0];
        else
            case_upper = value[0];
        cfg_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_reg(input logic idx, input logic [DATA_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== want)
            report_mismatch($sformatf("register %0d reads %h, want %h", idx, prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [FOLD_W-1:0] fw, input logic cf);
        pause_until_drained();
        write_reg(REG_FOLD_BITS, {26'd0, fw});
        check_reg(REG_FOLD_BITS, {26'd0, fold_width});
        write_reg(REG_CASE_FOLD, {31'd0, cf});
        check_reg(REG_CASE_FOLD, {31'd0, case_upper});
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte();
        int                kind;
        logic [BYTE_W-1:0] b;
        kind = $urandom_range(0, 19);
        if (kind < 11)
            b = BYTE_W'($urandom_range(8'h40, 8'h7F));
        else if (kind < 19)
            b = BYTE_W'($urandom_range(1, 255));
        else
            b = 8'h00;
        return b;
    endfunction

    // hash transfer checker
    always @(posedge aclk) begin
        m_ready <= !gaps_on || ($urandom_range(0, 99) >= 38);
        if (aresetn && m_valid && m_ready) begin
            if (expected_hashes.size() == 0) begin
                report_mismatch($sformatf("unexpected hash %h", m_hash_value));
            end else begin
                hash_want = expected_hashes.pop_front();
                hashes_seen++;
                if (m_hash_value !== hash_want)
                    report_mismatch($sformatf("hash %h, want %h", m_hash_value, hash_want));
            end
        end
    end

    task automatic test_register_reset();
        check_reg(REG_FOLD_BITS, {26'd0, FOLD_RESET});
        check_reg(REG_CASE_FOLD, 32'd0);
    endtask

    task automatic test_directed_keys();
        // empty key gives the offset basis
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h63, 1'b1);
        set_config(6'd32, 1'b1);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h63, 1'b1);
        send_byte(8'h7B, 1'b0);
        send_byte(8'h7C, 1'b0);
        send_byte(8'h7D, 1'b0);
        send_byte(8'h7E, 1'b1);
        // bytes outside the folded range stay as they are
        send_byte(8'h60, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b1);
        // zero stops hashing until the last byte
        send_byte(8'h78, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h79, 1'b0);
        send_byte(8'h7A, 1'b1);
        send_byte(8'h71, 1'b0);
        send_byte(8'h00, 1'b1);
        set_config(6'd1, 1'b1);
        send_byte(8'h61, 1'b1);
        set_config(6'd0, 1'b0);
        send_byte(8'h6B, 1'b1);
        set_config(6'd63, 1'b0);
        send_byte(8'h6B, 1'b1);
        set_config(6'd16, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_random_keys();
        logic [FOLD_W-1:0] fw;
        logic              cf;
        int                len;
        int                phase_start;
        for (int phase = 0; phase < 12; phase++) begin
            case (phase)
                0: fw = 6'd1;
                1: fw = 6'd32;
                2: fw = 6'd0;
                3: fw = 6'd63;
                default: begin
                    if ($urandom_range(0, 4) == 0)
                        fw = FOLD_W'($urandom_range(33, 63));
                    else
                        fw = FOLD_W'($urandom_range(1, 32));
                end
            endcase
            cf = (phase < 4) ? phase[0] : 1'($urandom_range(0, 1));
            set_config(fw, cf);
            gaps_on = (phase != 6);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < 145) begin
                if ($urandom_range(0, 3) == 0)
                    len = $urandom_range(13, 40);
                else
                    len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                    send_byte(pick_byte(), i == len - 1);
                if ($urandom_range(0, 39) == 0)
                    pause_until_drained();
            end
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_register_reset();
        test_directed_keys();
        test_random_keys();
        pause_until_drained();
        $display("sent %0d keys in %0d byte transfers, %0d register writes",
                 keys_sent, bytes_sent, cfg_writes);
        $display("compared %0d hashes across fold widths 0 to 63 with and without case fold",
                 hashes_seen);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/fnv1a_pkg.sv
rtl/fnv1a_front.sv
rtl/fnv1a_fifo.sv
rtl/fnv1a_back.sv
rtl/fnv1a_folded_string_hash.sv
tb/fnv1a_folded_string_hash_tb.sv
